// ===== design/iff_pkg.sv =====
`timescale 1ns / 1ps

package iff_pkg;

   // Digit store: 22 digits covers 64-bit octal; decimal needs 20, hex 16.
   localparam int DIGITS       = 22;
   localparam int DIGIT_W      = 4;
   localparam int STORE_W      = DIGITS * DIGIT_W;
   localparam int CNT_W        = $clog2(DIGITS + 1);
   localparam int VALUE_W      = 64;
   localparam int DABBLE_STEPS = VALUE_W;
   localparam int STEP_W       = $clog2(DABBLE_STEPS);

   localparam int MAX_FIELD_WIDTH_DEF = 64;

   localparam logic [1:0] RADIX_DEC   = 2'd0;
   localparam logic [1:0] RADIX_OCT   = 2'd1;
   localparam logic [1:0] RADIX_HEX_L = 2'd2;
   localparam logic [1:0] RADIX_HEX_U = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X_L   = 8'h78;
   localparam logic [7:0] CH_X_U   = 8'h58;
   localparam logic [7:0] CH_A_L   = 8'h61;
   localparam logic [7:0] CH_A_U   = 8'h41;

   typedef struct packed {
      logic                start;
      logic                take;
   } dig_ctl_type;

   typedef struct packed {
      logic                done;
      logic [DIGIT_W-1:0]  top;
      logic [CNT_W-1:0]    count;
   } dig_sts_type;

   function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
      logic [7:0] base;
      begin
         base = upper ? CH_A_U : CH_A_L;
         if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
         end else begin
            digit_char = base + {4'd0, d} - 8'd10;
         end
      end
   endfunction

endpackage

// ===== design/iff_digits.sv =====
`timescale 1ns / 1ps

module iff_digits (
   input  logic                           clock,
   input  logic                           reset,
   input  iff_pkg::dig_ctl_type           ctl,
   input  logic [iff_pkg::VALUE_W-1:0]    mag,
   input  logic [1:0]                     radix,
   output iff_pkg::dig_sts_type           sts
);
   import iff_pkg::*;

   typedef enum logic [1:0] {
      D_IDLE,
      D_DABBLE,
      D_NORM,
      D_READY
   } dstate_type;

   dstate_type           state_ff, state_in;
   logic [STORE_W-1:0]   dig_ff, dig_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     nd_ff, nd_in;

   logic [STORE_W-1:0]   corr;
   logic [STORE_W-1:0]   load;
   logic [DIGIT_W-1:0]   top_digit;

   assign top_digit = dig_ff[STORE_W-1 -: DIGIT_W];

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         if (dig_ff[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            corr[k*DIGIT_W +: DIGIT_W] = dig_ff[k*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            corr[k*DIGIT_W +: DIGIT_W] = dig_ff[k*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // octal and hex digits are plain bit slices of the magnitude
   always_comb begin
      load = '0;
      if (radix == RADIX_OCT) begin
         for (int k = 0; k < DIGITS - 1; k++) begin
            load[k*DIGIT_W +: DIGIT_W] = {1'b0, mag[3*k +: 3]};
         end
         load[(DIGITS-1)*DIGIT_W +: DIGIT_W] = {3'd0, mag[VALUE_W-1]};
      end else begin
         load[VALUE_W-1:0] = mag;
      end
   end

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      bin_in   = bin_ff;
      step_in  = step_ff;
      nd_in    = nd_ff;
      if (ctl.start) begin
         nd_in   = CNT_W'(DIGITS);
         step_in = '0;
         if (radix == RADIX_DEC) begin
            dig_in   = '0;
            bin_in   = mag;
            state_in = D_DABBLE;
         end else begin
            dig_in   = load;
            state_in = D_NORM;
         end
      end else begin
         case (state_ff)
            D_DABBLE: begin
               dig_in  = {corr[STORE_W-2:0], bin_ff[VALUE_W-1]};
               bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_W'(DABBLE_STEPS - 1)) begin
                  state_in = D_NORM;
               end
            end
            D_NORM: begin
               // strip leading zeros, keeping at least one digit
               if (top_digit == '0 && nd_ff > CNT_W'(1)) begin
                  dig_in = {dig_ff[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                  nd_in  = nd_ff - 1'b1;
               end else begin
                  state_in = D_READY;
               end
            end
            D_READY: begin
               if (ctl.take) begin
                  dig_in = {dig_ff[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dig_ff  <= dig_in;
      bin_ff  <= bin_in;
      step_ff <= step_in;
      nd_ff   <= nd_in;
   end

   assign sts.done  = (state_ff == D_READY);
   assign sts.top   = top_digit;
   assign sts.count = nd_ff;

endmodule

// ===== design/integer_field_formatter.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Ports                          Transfer
// req      in         req_valid/req_ready + fields   one conversion request
// rsp      out        rsp_valid/rsp_ready + fields   one character, last_char on the final one
//
// Decimal requests run a bit-serial double-dabble, then trim leading zero digits;
// octal and hex skip straight to the trim. The seven field sections follow in order
// (left pad, sign, zero pad, prefix zero, prefix x, digits, right pad), and req_ready
// returns once the last section ends; pad is at most 63 characters.
// Reset clears control only; no clearing pass. A stalled rsp_ready holds the emitter.
// req_ready is high only between requests.

module integer_field_formatter #(
   parameter int MAX_FIELD_WIDTH = iff_pkg::MAX_FIELD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [iff_pkg::VALUE_W-1:0] req_value,
   input  logic [1:0]                  req_value_size,
   input  logic                        req_is_signed,
   input  logic [1:0]                  req_radix_select,
   input  logic                        req_left_justify,
   input  logic                        req_force_plus,
   input  logic                        req_force_space,
   input  logic                        req_alternate_form,
   input  logic                        req_zero_pad,
   input  logic [6:0]                  req_field_width,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_last_char
);
   import iff_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_CONV,
      S_SETUP,
      S_LPAD,
      S_SIGN,
      S_ZPAD,
      S_PFX0,
      S_PFXX,
      S_DIGIT,
      S_RPAD
   } state_type;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [1:0]           radix_ff, radix_in;
   logic                 left_ff, left_in;
   logic                 zpad_ff, zpad_in;
   logic [7:0]           sign_ff, sign_in;
   logic [1:0]           pfx_ff, pfx_in;
   logic [6:0]           width_ff, width_in;
   logic [6:0]           pad_ff, pad_in;
   logic [6:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]     nd_ff, nd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   dig_ctl_type          dctl;
   dig_sts_type          dsts;

   logic                 accept;
   logic                 fire;
   logic                 emit;
   logic [7:0]           emit_char;
   logic [VALUE_W-1:0]   mask;
   logic                 msb;
   logic [VALUE_W-1:0]   cut;
   logic                 neg;
   logic [VALUE_W-1:0]   mag_now;
   logic [6:0]           content;
   logic [6:0]           max_w;

   assign max_w = 7'(MAX_FIELD_WIDTH);

   iff_digits u_digits (
      .clock (clock),
      .reset (reset),
      .ctl   (dctl),
      .mag   (mag_ff),
      .radix (radix_ff),
      .sts   (dsts)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (req_value_size)
         2'd0: begin
            mask = 64'h0000_0000_0000_00FF;
            msb  = req_value[7];
         end
         2'd1: begin
            mask = 64'h0000_0000_0000_FFFF;
            msb  = req_value[15];
         end
         2'd2: begin
            mask = 64'h0000_0000_FFFF_FFFF;
            msb  = req_value[31];
         end
         default: begin
            mask = '1;
            msb  = req_value[63];
         end
      endcase
      cut     = req_value & mask;
      neg     = req_is_signed && msb;
      mag_now = neg ? ((~cut + 64'd1) & mask) : cut;
   end

   assign content = 7'(nd_ff) + {5'd0, pfx_ff} + {6'd0, (sign_ff != 8'd0)};

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      radix_in     = radix_ff;
      left_in      = left_ff;
      zpad_in      = zpad_ff;
      sign_in      = sign_ff;
      pfx_in       = pfx_ff;
      width_in     = width_ff;
      pad_in       = pad_ff;
      rem_in       = rem_ff;
      nd_in        = nd_ff;
      dctl.start   = 1'b0;
      dctl.take    = 1'b0;
      emit         = 1'b0;
      emit_char    = CH_SPACE;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mag_in   = mag_now;
               radix_in = req_radix_select;
               left_in  = req_left_justify;
               zpad_in  = req_zero_pad;
               width_in = (req_field_width > max_w) ? max_w : req_field_width;
               if (neg) begin
                  sign_in = CH_MINUS;
               end else if (req_force_plus) begin
                  sign_in = CH_PLUS;
               end else if (req_force_space) begin
                  sign_in = CH_SPACE;
               end else begin
                  sign_in = 8'd0;
               end
               // no prefix on a zero value
               if (req_alternate_form && mag_now != '0) begin
                  if (req_radix_select == RADIX_HEX_L || req_radix_select == RADIX_HEX_U) begin
                     pfx_in = 2'd2;
                  end else if (req_radix_select == RADIX_OCT) begin
                     pfx_in = 2'd1;
                  end else begin
                     pfx_in = 2'd0;
                  end
               end else begin
                  pfx_in = 2'd0;
               end
               state_in = S_START;
            end
         end
         S_START: begin
            dctl.start = 1'b1;
            state_in   = S_CONV;
         end
         S_CONV: begin
            if (dsts.done) begin
               nd_in    = dsts.count;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            pad_in   = (width_ff > content) ? (width_ff - content) : 7'd0;
            rem_in   = (width_ff > content) ? width_ff : content;
            state_in = S_LPAD;
         end
         S_LPAD: begin
            if (pad_ff == 7'd0 || left_ff || zpad_ff) begin
               state_in = S_SIGN;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = CH_SPACE;
               pad_in    = pad_ff - 1'b1;
            end
         end
         S_SIGN: begin
            if (sign_ff == 8'd0) begin
               state_in = S_ZPAD;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = sign_ff;
               state_in  = S_ZPAD;
            end
         end
         S_ZPAD: begin
            if (pad_ff == 7'd0 || left_ff || !zpad_ff) begin
               state_in = S_PFX0;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = CH_ZERO;
               pad_in    = pad_ff - 1'b1;
            end
         end
         S_PFX0: begin
            if (pfx_ff == 2'd0) begin
               state_in = S_PFXX;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = CH_ZERO;
               state_in  = S_PFXX;
            end
         end
         S_PFXX: begin
            if (pfx_ff != 2'd2) begin
               state_in = S_DIGIT;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = (radix_ff == RADIX_HEX_U) ? CH_X_U : CH_X_L;
               state_in  = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (nd_ff == '0) begin
               state_in = S_RPAD;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = digit_char(dsts.top, radix_ff == RADIX_HEX_U);
               dctl.take = 1'b1;
               nd_in     = nd_ff - 1'b1;
            end
         end
         S_RPAD: begin
            if (pad_ff == 7'd0 || !left_ff) begin
               state_in = S_IDLE;
            end else if (fire) begin
               emit      = 1'b1;
               emit_char = CH_SPACE;
               pad_in    = pad_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rem_in = rem_ff - 1'b1;
      end

      // output register: load on emit, drop on transfer
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = (rem_ff == 7'd1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      radix_ff    <= radix_in;
      left_ff     <= left_in;
      zpad_ff     <= zpad_in;
      sign_ff     <= sign_in;
      pfx_ff      <= pfx_in;
      width_ff    <= width_in;
      pad_ff      <= pad_in;
      rem_ff      <= rem_in;
      nd_ff       <= nd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import iff_pkg::*;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   localparam int FIELD_MAX     = MAX_FIELD_WIDTH_DEF;
   localparam int RANDOM_ITEMS  = 435;
   localparam int STALL_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 200;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  size;
      logic        sgn;
      logic [1:0]  radix;
      logic        left;
      logic        plus;
      logic        space;
      logic        alt;
      logic        zpad;
      logic [6:0]  width;
   } conv_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value = '0;
   logic [1:0]  req_value_size = '0;
   logic        req_is_signed = 1'b0;
   logic [1:0]  req_radix_select = '0;
   logic        req_left_justify = 1'b0;
   logic        req_force_plus = 1'b0;
   logic        req_force_space = 1'b0;
   logic        req_alternate_form = 1'b0;
   logic        req_zero_pad = 1'b0;
   logic [6:0]  req_field_width = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;

   conv_req_type   dir_reqs[$];
   string          dir_texts[$];
   string          typed_texts[$];
   field_char_type pending_chars[$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned idle_cycles   = 0;
   int unsigned errors        = 0;

   integer_field_formatter u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_value_size     (req_value_size),
      .req_is_signed      (req_is_signed),
      .req_radix_select   (req_radix_select),
      .req_left_justify   (req_left_justify),
      .req_force_plus     (req_force_plus),
      .req_force_space    (req_force_space),
      .req_alternate_form (req_alternate_form),
      .req_zero_pad       (req_zero_pad),
      .req_field_width    (req_field_width),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Expected characters of one conversion, in print order.
   task automatic format_conversion(input conv_req_type r);
      int unsigned nbits, base, prefix_len, content, w, pad, i;
      logic [63:0] mask, mag;
      logic        neg, nonzero;
      logic [3:0]  d;
      logic [7:0]  sign_ch;
      logic [7:0]  digits[$];
      logic [7:0]  field[$];
      begin
         nbits = 8 << r.size;
         mask  = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
         mag   = r.value & mask;
         neg   = r.sgn && mag[nbits-1];
         if (neg) begin
            mag = (~mag + 64'd1) & mask;
         end
         nonzero = (mag != 0);
         base = (r.radix == RADIX_DEC) ? 10 : (r.radix == RADIX_OCT) ? 8 : 16;
         do begin
            d = 4'(mag % base);
            if (d < 10) begin
               digits.push_front(CH_ZERO + {4'd0, d});
            end else begin
               digits.push_front(((r.radix == RADIX_HEX_U) ? CH_A_U : CH_A_L)
                                 + {4'd0, d} - 8'd10);
            end
            mag = mag / base;
         end while (mag != 0);

         prefix_len = 0;
         if (r.alt && nonzero) begin
            if (r.radix == RADIX_HEX_L || r.radix == RADIX_HEX_U) begin
               prefix_len = 2;
            end else if (r.radix == RADIX_OCT) begin
               prefix_len = 1;
            end
         end
         sign_ch = neg ? CH_MINUS : r.plus ? CH_PLUS : r.space ? CH_SPACE : 8'd0;

         content = digits.size() + prefix_len + ((sign_ch != 0) ? 1 : 0);
         w   = (r.width > FIELD_MAX) ? FIELD_MAX : r.width;
         pad = (w > content) ? w - content : 0;

         if (!r.left && !r.zpad) begin
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
         end
         if (sign_ch != 0) begin
            field.push_back(sign_ch);
         end
         if (!r.left && r.zpad) begin
            for (i = 0; i < pad; i++) field.push_back(CH_ZERO);
         end
         if (prefix_len != 0) begin
            field.push_back(CH_ZERO);
         end
         if (prefix_len == 2) begin
            field.push_back((r.radix == RADIX_HEX_U) ? CH_X_U : CH_X_L);
         end
         for (i = 0; i < digits.size(); i++) field.push_back(digits[i]);
         if (r.left) begin
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
         end

         for (i = 0; i < field.size(); i++) begin
            pending_chars.push_back('{ch: field[i], last: (i == field.size() - 1)});
         end
      end
   endtask

   task automatic queue_text(input string s);
      int i;
      begin
         for (i = 0; i < s.len(); i++) begin
            pending_chars.push_back('{ch: 8'(s[i]), last: (i == s.len() - 1)});
         end
      end
   endtask

   // Request side is sampled here as well, so expectations are queued before
   // any character of the same request can be checked.
   always @(posedge clock) begin
      field_char_type exp_char;
      conv_req_type   acc;
      string          text;
      if (!reset) begin
         if (req_valid && req_ready) begin
            acc = '{value: req_value, size: req_value_size, sgn: req_is_signed,
                    radix: req_radix_select, left: req_left_justify,
                    plus: req_force_plus, space: req_force_space,
                    alt: req_alternate_form, zpad: req_zero_pad,
                    width: req_field_width};
            text = typed_texts.pop_front();
            if (text.len() != 0) begin
               queue_text(text);
            end else begin
               format_conversion(acc);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected character transfer: out_char=%h last_char=%b",
                      rsp_out_char, rsp_last_char);
               errors++;
            end else begin
               exp_char = pending_chars.pop_front();
               if (rsp_out_char !== exp_char.ch) begin
                  $error("out_char: expected %h, actual %h", exp_char.ch, rsp_out_char);
                  errors++;
               end
               if (rsp_last_char !== exp_char.last) begin
                  $error("last_char: expected %b, actual %b", exp_char.last,
                         rsp_last_char);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic add_row(input logic [63:0] value, input logic [1:0] size,
                          input logic sgn, input logic [1:0] radix,
                          input logic left, input logic plus, input logic space,
                          input logic alt, input logic zpad, input logic [6:0] width,
                          input string text);
      begin
         dir_reqs.push_back('{value: value, size: size, sgn: sgn, radix: radix,
                              left: left, plus: plus, space: space, alt: alt,
                              zpad: zpad, width: width});
         dir_texts.push_back(text);
      end
   endtask

   function automatic conv_req_type random_conversion();
      conv_req_type r;
      begin
         r.size  = 2'($urandom_range(3));
         r.sgn   = 1'($urandom_range(1));
         r.radix = 2'($urandom_range(3));
         r.left  = 1'($urandom_range(1));
         r.plus  = 1'($urandom_range(1));
         r.space = 1'($urandom_range(1));
         r.alt   = 1'($urandom_range(1));
         r.zpad  = 1'($urandom_range(1));
         r.width = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(26));
         case ($urandom_range(3))
            0: r.value = {$urandom, $urandom};
            1: r.value = 64'($urandom_range(300));
            // powers of two and the values just below them hit every sign boundary
            2: r.value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
            default: r.value = ~{32'd0, $urandom_range(300)};
         endcase
         return r;
      end
   endfunction

   task automatic send_conversion(input conv_req_type r, input string text);
      int gap;
      begin
         gap = 0;
         while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         typed_texts.push_back(text);
         req_valid          <= 1'b1;
         req_value          <= r.value;
         req_value_size     <= r.size;
         req_is_signed      <= r.sgn;
         req_radix_select   <= r.radix;
         req_left_justify   <= r.left;
         req_force_plus     <= r.plus;
         req_force_space    <= r.space;
         req_alternate_form <= r.alt;
         req_zero_pad       <= r.zpad;
         req_field_width    <= r.width;
         do @(posedge clock); while (!req_ready);
      end
   endtask

   initial begin
      int total, k, phase;
      //       value                   size     sgn  radix        lft  pls  spc  alt  zpd  wid
      add_row(64'd0,                  SIZE_64, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "0");
      add_row(64'hFF,                 SIZE_8,  1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "255");
      add_row(64'hFF,                 SIZE_8,  1'b1, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "-1");
      add_row(64'h80,                 SIZE_8,  1'b1, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "-128");
      add_row('1,                     SIZE_64, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "18446744073709551615");
      add_row(64'h8000_0000_0000_0000, SIZE_64, 1'b1, RADIX_DEC,  1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "-9223372036854775808");
      add_row(64'hDEAD_BEEF,          SIZE_32, 1'b0, RADIX_HEX_L, 1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "0xdeadbeef");
      add_row(64'hDEAD_BEEF,          SIZE_32, 1'b0, RADIX_HEX_U, 1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "0XDEADBEEF");
      add_row(64'd0,                  SIZE_32, 1'b0, RADIX_HEX_L, 1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "0");
      add_row(64'd0,                  SIZE_32, 1'b0, RADIX_OCT,   1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "0");
      add_row(64'd8,                  SIZE_32, 1'b0, RADIX_OCT,   1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "010");
      add_row(64'd42,                 SIZE_32, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "42");
      add_row(64'd42,                 SIZE_32, 1'b1, RADIX_DEC,   1'b0,1'b1,1'b1,1'b0,1'b0,7'd0,
              "+42");
      add_row(64'd42,                 SIZE_32, 1'b1, RADIX_DEC,   1'b0,1'b0,1'b1,1'b0,1'b0,7'd0,
              " 42");
      add_row(64'd42,                 SIZE_32, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd6,
              "    42");
      add_row(64'hD6,                 SIZE_8,  1'b1, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b1,7'd6,
              "-00042");
      add_row(64'd42,                 SIZE_32, 1'b0, RADIX_DEC,   1'b1,1'b0,1'b0,1'b0,1'b1,7'd5,
              "42   ");
      add_row(64'h1234,               SIZE_16, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd2,
              "4660");
      add_row(64'hF0,                 SIZE_8,  1'b1, RADIX_HEX_L, 1'b0,1'b0,1'b0,1'b1,1'b0,7'd0,
              "-0x10");
      add_row(64'h1234_5678_9ABC_DEF0, SIZE_8, 1'b0, RADIX_HEX_U, 1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "F0");
      add_row(64'h8000,               SIZE_16, 1'b1, RADIX_OCT,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd0,
              "-100000");
      add_row(64'd42,                 SIZE_32, 1'b0, RADIX_DEC,   1'b0,1'b0,1'b0,1'b0,1'b0,7'd127,
              "");
      add_row(64'd42,                 SIZE_32, 1'b1, RADIX_DEC,   1'b1,1'b1,1'b0,1'b0,1'b0,7'd64,
              "");
      add_row('1,                     SIZE_64, 1'b0, RADIX_HEX_U, 1'b0,1'b1,1'b0,1'b1,1'b1,7'd64,
              "");
      add_row('1,                     SIZE_64, 1'b0, RADIX_OCT,   1'b0,1'b0,1'b0,1'b1,1'b0,7'd65,
              "");

      total = dir_reqs.size() + RANDOM_ITEMS;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < total; k++) begin
         phase = (k * 3) / total;
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 51 : 0;
         rsp_idle_pct  = (phase == 0) ? 51 : (phase == 1) ? 33 : 0;
         if (k < dir_reqs.size()) begin
            send_conversion(dir_reqs[k], dir_texts[k]);
         end else begin
            send_conversion(random_conversion(), "");
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && pending_chars.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/iff_pkg.sv
design/iff_digits.sv
design/integer_field_formatter.sv
test/tb.sv
